// ===== rtl/core/bctp_pkg.sv =====
package bctp_pkg;

	localparam int MAX_OUT_LEVELS_DEF = 32;
	localparam int MAX_IN_LEVELS_DEF  = 32;
	localparam int ROW_CAP            = 32;
	localparam int LVL_W              = 6;
	localparam int IDX_W              = 5;
	localparam int ELEM_W             = 16;
	localparam int PART_W             = 48;
	localparam int OUT_W              = 64;
	localparam int ACC_W              = 72;

	localparam logic [1:0] FUNC_WR_REG = 2'd0;
	localparam logic [1:0] FUNC_WR_COV = 2'd1;
	localparam logic [1:0] FUNC_COMPUTE = 2'd2;
	localparam logic [1:0] FUNC_RSVD   = 2'd3;

	localparam logic CFG_OUT_LEVELS = 1'b0;
	localparam logic CFG_IN_LEVELS  = 1'b1;

	typedef struct packed {
		logic [1:0]               func;
		logic [IDX_W-1:0]         row_index;
		logic [IDX_W-1:0]         col_index;
		logic signed [ELEM_W-1:0] elem_value;
	} in_beat_t;

	typedef struct packed {
		logic [IDX_W-1:0]        out_col;
		logic signed [OUT_W-1:0] out_value;
		logic                    last_in_row;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P1,
		ST_P1_END,
		ST_P2,
		ST_P2_END,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clr_acc;
		logic mac1;
		logic mac2;
		logic store_part;
	} cmd_t;

endpackage

// ===== rtl/core/balanced_covariance_triple_product.sv =====
// Computes rows of R*C*R^T. Load beats (func 0/1) write the R or C store.
// A compute beat for row i runs a first pass of multiply-accumulate through the
// single multiplier, one partial sum per input column, then for each of nout
// output columns a second pass over nin terms plus one emit beat; the shared
// multiplier and the single read port of each store set the row time. Input
// stall is high while a row is computed.
module balanced_covariance_triple_product #(
	parameter int MAX_OUT_LEVELS = bctp_pkg::MAX_OUT_LEVELS_DEF,
	parameter int MAX_IN_LEVELS  = bctp_pkg::MAX_IN_LEVELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [5:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  bctp_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bctp_pkg::out_beat_t out_data
);
	localparam int OW = (MAX_OUT_LEVELS > 1) ? $clog2(MAX_OUT_LEVELS) : 1;
	localparam int IW = (MAX_IN_LEVELS > 1) ? $clog2(MAX_IN_LEVELS) : 1;
	localparam int OCAP = (MAX_OUT_LEVELS < bctp_pkg::ROW_CAP) ? MAX_OUT_LEVELS
		: bctp_pkg::ROW_CAP;

	logic [5:0] out_lv_q, in_lv_q;
	logic [6:0] nout, nin;
	logic busy, acc, start, wr_reg, wr_cov, last;
	logic [OW-1:0] row_q, k_q;
	logic [IW-1:0] a_q, b_q;
	bctp_pkg::cmd_t cmd;
	logic signed [63:0] result;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_lv_q <= 6'd1; in_lv_q <= 6'd1;
		end else if (cfg_we) begin
			if (cfg_index == bctp_pkg::CFG_OUT_LEVELS) out_lv_q <= cfg_data;
			else in_lv_q <= cfg_data;
		end
	end

	// clamp levels
	always_comb begin
		nout = (out_lv_q == 0) ? 7'd1 : ({1'b0, out_lv_q} > 7'(OCAP)) ? 7'(OCAP)
			: {1'b0, out_lv_q};
		nin = (in_lv_q == 0) ? 7'd1 : ({1'b0, in_lv_q} > 7'(MAX_IN_LEVELS))
			? 7'(MAX_IN_LEVELS) : {1'b0, in_lv_q};
	end

	assign in_stall = busy;
	assign acc = in_valid && !busy;
	assign wr_reg = acc && in_data.func == bctp_pkg::FUNC_WR_REG
		&& 32'(in_data.row_index) < MAX_OUT_LEVELS && 32'(in_data.col_index) < MAX_IN_LEVELS;
	assign wr_cov = acc && in_data.func == bctp_pkg::FUNC_WR_COV
		&& 32'(in_data.row_index) < MAX_IN_LEVELS && 32'(in_data.col_index) < MAX_IN_LEVELS;
	assign start = acc && in_data.func == bctp_pkg::FUNC_COMPUTE
		&& {2'b0, in_data.row_index} < nout;

	bctp_ctrl #(.MAX_OUT_LEVELS(MAX_OUT_LEVELS), .MAX_IN_LEVELS(MAX_IN_LEVELS)) u_ctrl (
		.clk, .arst_n, .start, .start_row(in_data.row_index), .nout, .nin,
		.out_stall, .busy, .out_valid, .out_last(last), .row_q, .k_q, .a_q, .b_q, .cmd
	);

	bctp_datapath #(.MAX_OUT_LEVELS(MAX_OUT_LEVELS), .MAX_IN_LEVELS(MAX_IN_LEVELS)) u_dp (
		.clk, .wr_reg, .wr_cov, .wr_beat(in_data), .row_q, .k_q, .a_q, .b_q, .cmd, .result
	);

	assign out_data.out_col = 5'(k_q);
	assign out_data.out_value = result;
	assign out_data.last_in_row = last;
endmodule

// ===== rtl/core/bctp_datapath.sv =====
module bctp_datapath #(
	parameter int MAX_OUT_LEVELS = bctp_pkg::MAX_OUT_LEVELS_DEF,
	parameter int MAX_IN_LEVELS  = bctp_pkg::MAX_IN_LEVELS_DEF,
	localparam int OW = (MAX_OUT_LEVELS > 1) ? $clog2(MAX_OUT_LEVELS) : 1,
	localparam int IW = (MAX_IN_LEVELS > 1) ? $clog2(MAX_IN_LEVELS) : 1
) (
	input  logic                clk,
	input  logic                wr_reg,
	input  logic                wr_cov,
	input  bctp_pkg::in_beat_t  wr_beat,
	input  logic [OW-1:0]       row_q,
	input  logic [OW-1:0]       k_q,
	input  logic [IW-1:0]       a_q,
	input  logic [IW-1:0]       b_q,
	input  bctp_pkg::cmd_t      cmd,
	output logic signed [bctp_pkg::OUT_W-1:0] result
);
	localparam int RD = MAX_OUT_LEVELS * MAX_IN_LEVELS;
	localparam int CD = MAX_IN_LEVELS * MAX_IN_LEVELS;
	localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
	localparam int CAW = (CD > 1) ? $clog2(CD) : 1;

	logic signed [bctp_pkg::ELEM_W-1:0] reg_mem [RD];
	logic signed [bctp_pkg::ELEM_W-1:0] cov_mem [CD];
	logic signed [bctp_pkg::PART_W-1:0] part_mem [MAX_IN_LEVELS];
	logic signed [bctp_pkg::ELEM_W-1:0] r_s1, c_s1;
	logic signed [bctp_pkg::PART_W-1:0] p_s1;
	logic mac1_s1, mac2_s1;
	logic signed [bctp_pkg::ACC_W-1:0] acc_q;
	logic signed [63:0] prod_s2;
	logic mac_s2;
	logic [RAW-1:0] wr_r_addr, r_addr;
	logic [CAW-1:0] wr_c_addr, c_addr;

	// store addresses
	assign wr_r_addr = RAW'(int'(wr_beat.row_index[OW-1:0]) * MAX_IN_LEVELS
		+ int'(wr_beat.col_index[IW-1:0]));
	assign wr_c_addr = CAW'(int'(wr_beat.row_index[IW-1:0]) * MAX_IN_LEVELS
		+ int'(wr_beat.col_index[IW-1:0]));
	assign r_addr = cmd.mac2 ? RAW'(int'(k_q) * MAX_IN_LEVELS + int'(b_q))
		: RAW'(int'(row_q) * MAX_IN_LEVELS + int'(a_q));
	assign c_addr = CAW'(int'(a_q) * MAX_IN_LEVELS + int'(b_q));

	// store writes
	always_ff @(posedge clk) begin
		if (wr_reg)
			reg_mem[wr_r_addr] <= wr_beat.elem_value;
		if (wr_cov)
			cov_mem[wr_c_addr] <= wr_beat.elem_value;
	end

	// registered reads: R row x a (phase 1) or R row k x b (phase 2), C a x b, partial b
	always_ff @(posedge clk) begin
		r_s1 <= reg_mem[r_addr];
		c_s1 <= cov_mem[c_addr];
		p_s1 <= part_mem[b_q];
		mac1_s1 <= cmd.mac1;
		mac2_s1 <= cmd.mac2;
	end

	// one multiply per cycle
	always_ff @(posedge clk) begin
		if (mac1_s1) prod_s2 <= 64'(32'(r_s1) * 32'(c_s1));
		else         prod_s2 <= 64'(p_s1) * 64'(r_s1);
		mac_s2 <= mac1_s1 | mac2_s1;
	end

	// accumulate
	always_ff @(posedge clk) begin
		if (cmd.clr_acc)   acc_q <= '0;
		else if (mac_s2)   acc_q <= acc_q + bctp_pkg::ACC_W'(prod_s2);
	end

	always_ff @(posedge clk) begin
		if (cmd.store_part) part_mem[b_q] <= acc_q[bctp_pkg::PART_W-1:0];
	end

	// saturate to 64 bits
	always_comb begin
		if (acc_q > $signed({{(bctp_pkg::ACC_W-64){1'b0}}, 1'b0, {63{1'b1}}}))
			result = {1'b0, {63{1'b1}}};
		else if (acc_q < $signed({{(bctp_pkg::ACC_W-64){1'b1}}, 1'b1, {63{1'b0}}}))
			result = {1'b1, {63{1'b0}}};
		else
			result = acc_q[63:0];
	end
endmodule

// ===== rtl/core/bctp_ctrl.sv =====
module bctp_ctrl #(
	parameter int MAX_OUT_LEVELS = bctp_pkg::MAX_OUT_LEVELS_DEF,
	parameter int MAX_IN_LEVELS  = bctp_pkg::MAX_IN_LEVELS_DEF,
	localparam int OW = (MAX_OUT_LEVELS > 1) ? $clog2(MAX_OUT_LEVELS) : 1,
	localparam int IW = (MAX_IN_LEVELS > 1) ? $clog2(MAX_IN_LEVELS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [bctp_pkg::IDX_W-1:0] start_row,
	input  logic [bctp_pkg::LVL_W:0]   nout,
	input  logic [bctp_pkg::LVL_W:0]   nin,
	input  logic                 out_stall,
	output logic                 busy,
	output logic                 out_valid,
	output logic                 out_last,
	output logic [OW-1:0]        row_q,
	output logic [OW-1:0]        k_q,
	output logic [IW-1:0]        a_q,
	output logic [IW-1:0]        b_q,
	output bctp_pkg::cmd_t       cmd
);
	bctp_pkg::state_t st_q, st_d;
	logic [1:0] drain_q;
	logic a_last, b_last, k_last;

	assign a_last = ((bctp_pkg::LVL_W+1)'(a_q) == nin - 7'd1);
	assign b_last = ((bctp_pkg::LVL_W+1)'(b_q) == nin - 7'd1);
	assign k_last = ((bctp_pkg::LVL_W+1)'(k_q) == nout - 7'd1);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			bctp_pkg::ST_IDLE:   if (start) st_d = bctp_pkg::ST_P1;
			bctp_pkg::ST_P1:     if (a_last) st_d = bctp_pkg::ST_P1_END;
			bctp_pkg::ST_P1_END: if (drain_q == 2'd3)
				st_d = b_last ? bctp_pkg::ST_P2 : bctp_pkg::ST_P1;
			bctp_pkg::ST_P2:     if (b_last) st_d = bctp_pkg::ST_P2_END;
			bctp_pkg::ST_P2_END: if (drain_q == 2'd3) st_d = bctp_pkg::ST_EMIT;
			bctp_pkg::ST_EMIT:   if (!out_stall)
				st_d = k_last ? bctp_pkg::ST_IDLE : bctp_pkg::ST_P2;
			default: st_d = bctp_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = (st_q != bctp_pkg::ST_IDLE);
		out_valid = (st_q == bctp_pkg::ST_EMIT);
		out_last = k_last;
		case (st_q)
			bctp_pkg::ST_IDLE: cmd.clr_acc = 1'b1;
			bctp_pkg::ST_P1:   cmd.mac1 = 1'b1;
			bctp_pkg::ST_P1_END: begin
				// store the finished column sum and start the next one from zero
				cmd.store_part = (drain_q == 2'd3);
				cmd.clr_acc = (drain_q == 2'd3);
			end
			bctp_pkg::ST_P2:   cmd.mac2 = 1'b1;
			bctp_pkg::ST_P2_END: ;
			bctp_pkg::ST_EMIT: cmd.clr_acc = !out_stall;
			default: ;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= bctp_pkg::ST_IDLE;
			drain_q <= '0;
			row_q <= '0; k_q <= '0; a_q <= '0; b_q <= '0;
		end else begin
			st_q <= st_d;
			case (st_q)
				bctp_pkg::ST_IDLE: if (start) begin
					row_q <= start_row[OW-1:0];
					a_q <= '0; b_q <= '0; k_q <= '0; drain_q <= '0;
				end
				bctp_pkg::ST_P1: begin
					drain_q <= '0;
					if (!a_last) a_q <= a_q + 1'b1;
				end
				bctp_pkg::ST_P1_END: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd3) begin
						a_q <= '0;
						if (!b_last) b_q <= b_q + 1'b1;
						else b_q <= '0;
					end
				end
				bctp_pkg::ST_P2: begin
					drain_q <= '0;
					if (!b_last) b_q <= b_q + 1'b1;
				end
				bctp_pkg::ST_P2_END: drain_q <= drain_q + 1'b1;
				bctp_pkg::ST_EMIT: if (!out_stall) begin
					b_q <= '0;
					k_q <= k_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_emit_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == bctp_pkg::ST_EMIT) |-> ($past(st_q) == bctp_pkg::ST_P2_END
		|| $past(st_q) == bctp_pkg::ST_EMIT)) else $error("emit entered badly");
	a_no_mac_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(cmd.mac1 || cmd.mac2)) else $error("mac during emit");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(k_q))) else $error("emit dropped");
`endif
endmodule
